// ===== hdl/ple_pkg.sv =====
// Shared types and constants for the positional list engine.
// Used by ple_ctrl, ple_datapath and positional_list_engine; no dependencies.
package ple_pkg;

  // list storage
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);

  // word field widths
  localparam int MODE_W      = 2;
  localparam int POS_A_W     = 7;
  localparam int POS_B_W     = 6;
  localparam int VALUE_W     = 32;
  localparam int LEN_W       = 7;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 8;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_MOVE   = 2'd2,
    MODE_MERGE  = 2'd3
  } mode_t;

  // memory read address select
  typedef enum logic [1:0] {
    RD_FETCH      = 2'd0,
    RD_FETCH_NEXT = 2'd1,
    RD_NEIGHBOR   = 2'd2
  } rd_sel_t;

  // controller to datapath
  typedef struct packed {
    logic    capture;
    logic    setup;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    hold_load;
    logic    hold_add;
    logic    wr_shift;
    logic    wr_final;
    logic    out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ok;
    logic trivial;
    logic needs_fetch;
    logic is_merge;
    logic at_end;
    logic has_final;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hdl/positional_list_engine.sv =====
// Sequence: m_tvalid rises once the result register is loaded; a rejected word or a same-position move
// goes from the check straight to the result, while an applied word first fetches (move, merge), then walks
// the shifted elements, each one read and then written, and writes the final element (all but delete).
// Throughput: one word at a time; the next word is accepted the cycle after the result
// is registered, even while that result still waits on m_tready.
// Reset: rst (synchronous) empties the list and drops any pending result word.
module positional_list_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // s_tdata: mode[1:0], position_a[8:2], position_b[14:9], value[46:15], zero[47]
  input  logic [ple_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // m_tdata: ok[0], length[7:1]
  output logic [ple_pkg::OUT_TDATA_W-1:0]     m_tdata
);

  ple_pkg::dp_cmd_t    cmd;
  ple_pkg::dp_status_t status;

  ple_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ple_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tready (m_tready)
  );

`ifndef SYNTHESIS
  // one word in flight: no accept in the cycle after an accept
  a_single_word: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("word accepted while previous word in flight");

  // never overwrite a result word that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result register overwritten");

  // shift writes only happen before the walk reaches its end
  a_shift_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_shift |-> !status.at_end)
    else $error("shift past end of walk");

  // reported length stays within capacity
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:1] <= ple_pkg::LEN_W'(ple_pkg::CAPACITY)))
    else $error("length beyond capacity");
`endif

endmodule

// ===== hdl/ple_ctrl.sv =====
// Sequencer for the positional list engine: steps one operation through
// check, fetch, element shifting, final write and result. Uses ple_pkg.
module ple_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  ple_pkg::dp_status_t status,
  output ple_pkg::dp_cmd_t    cmd
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_CHECK    = 9'b000000010,
    S_FETCH    = 9'b000000100,
    S_HOLD     = 9'b000001000,
    S_SUM      = 9'b000010000,
    S_SHIFT_RD = 9'b000100000,
    S_SHIFT_WR = 9'b001000000,
    S_FINAL    = 9'b010000000,
    S_RESULT   = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.rd_sel    = ple_pkg::RD_FETCH;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.setup = 1'b1;
        if (!status.ok || status.trivial) begin
          state_next = S_RESULT;
        end else if (status.needs_fetch) begin
          state_next = S_FETCH;
        end else begin
          state_next = S_SHIFT_RD;
        end
      end
      S_FETCH: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ple_pkg::RD_FETCH;
        state_next = S_HOLD;
      end
      S_HOLD: begin
        cmd.hold_load = 1'b1;
        if (status.is_merge) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ple_pkg::RD_FETCH_NEXT;
          state_next = S_SUM;
        end else begin
          state_next = S_SHIFT_RD;
        end
      end
      S_SUM: begin
        cmd.hold_add = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      S_SHIFT_RD: begin
        if (status.at_end) begin
          state_next = status.has_final ? S_FINAL : S_RESULT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ple_pkg::RD_NEIGHBOR;
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      S_FINAL: begin
        cmd.wr_final = 1'b1;
        state_next   = S_RESULT;
      end
      S_RESULT: begin
        // wait for the output register to free up
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/ple_datapath.sv =====
// Datapath of the positional list engine: element memory, operation decode,
// shift cursor, held value, length register and result register. Uses ple_pkg.
module ple_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [ple_pkg::IN_TDATA_W-1:0]       s_tdata,
  input  ple_pkg::dp_cmd_t                     cmd,
  output ple_pkg::dp_status_t                  status,
  output logic                                 m_tvalid,
  output logic [ple_pkg::OUT_TDATA_W-1:0]      m_tdata,
  input  logic                                 m_tready
);

  localparam int AW = ple_pkg::ADDR_W;
  localparam int LW = ple_pkg::LEN_W;
  localparam int VW = ple_pkg::VALUE_W;

  // captured word
  ple_pkg::mode_t                  op;
  logic [ple_pkg::POS_A_W-1:0]     pos_a;
  logic [ple_pkg::POS_B_W-1:0]     pos_b;
  logic [VW-1:0]                   value;

  // list state
  logic [VW-1:0]  mem [ple_pkg::CAPACITY];
  logic [VW-1:0]  rd_data;
  logic [LW-1:0]  element_count;
  logic [LW-1:0]  count_next;

  // sequencing registers
  logic [AW-1:0]  cursor;
  logic [AW-1:0]  last_addr;
  logic [AW-1:0]  fin_addr;
  logic [AW-1:0]  fetch_addr;
  logic           dir_up;
  logic           has_final;
  logic [VW-1:0]  held;

  // result register
  logic           out_valid;
  logic           out_ok;
  logic [LW-1:0]  out_len;

  // decode
  logic [LW-1:0]  pb_ext;
  logic [LW:0]    pa_inc;
  logic [LW:0]    pb_inc;
  logic [LW-1:0]  lo;
  logic [LW:0]    hi;
  logic           same;
  logic           adjacent;
  logic           not_empty;
  logic           ok;

  logic [AW-1:0]  cursor_init;
  logic [AW-1:0]  last_init;
  logic [AW-1:0]  fin_init;
  logic           dir_init;
  logic           final_init;
  logic [LW-1:0]  count_last;

  logic [AW-1:0]  neighbor;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [VW-1:0]  wr_data;

  assign pb_ext     = {1'b0, pos_b};
  assign pa_inc     = {1'b0, pos_a} + (LW + 1)'(1);
  assign pb_inc     = {2'b00, pos_b} + (LW + 1)'(1);
  assign same       = (pos_a == pb_ext);
  assign adjacent   = (pa_inc == {1'b0, pb_ext}) || (pb_inc == {1'b0, pos_a});
  assign lo         = (pos_a < pb_ext) ? pos_a : pb_ext;
  assign hi         = {1'b0, lo} + (LW + 1)'(1);
  assign not_empty  = (element_count != '0);
  assign count_last = element_count - LW'(1);

  // accept or reject, and setup of the shift walk
  always_comb begin
    ok          = 1'b0;
    count_next  = element_count;
    cursor_init = pos_a[AW-1:0];
    last_init   = count_last[AW-1:0];
    fin_init    = pos_a[AW-1:0];
    dir_init    = 1'b1;
    final_init  = 1'b1;
    case (op)
      ple_pkg::MODE_INSERT: begin
        ok          = (element_count < LW'(ple_pkg::CAPACITY)) && (pos_a <= element_count);
        count_next  = ok ? element_count + LW'(1) : element_count;
        cursor_init = element_count[AW-1:0];
        last_init   = pos_a[AW-1:0];
        dir_init    = 1'b0;
      end
      ple_pkg::MODE_DELETE: begin
        ok          = not_empty && (pos_a < element_count);
        count_next  = ok ? count_last : element_count;
        final_init  = 1'b0;
      end
      ple_pkg::MODE_MOVE: begin
        ok          = not_empty && (same || ((pos_a < element_count) && (pb_ext < element_count)));
        last_init   = pos_b[AW-1:0];
        fin_init    = pos_b[AW-1:0];
        dir_init    = (pos_a < pb_ext);
      end
      ple_pkg::MODE_MERGE: begin
        ok          = not_empty && adjacent && (hi < {1'b0, element_count});
        count_next  = ok ? count_last : element_count;
        cursor_init = hi[AW-1:0];
        fin_init    = lo[AW-1:0];
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign status.ok          = ok;
  assign status.trivial     = (op == ple_pkg::MODE_MOVE) && same;
  assign status.needs_fetch = (op == ple_pkg::MODE_MOVE) || (op == ple_pkg::MODE_MERGE);
  assign status.is_merge    = (op == ple_pkg::MODE_MERGE);
  assign status.at_end      = (cursor == last_addr);
  assign status.has_final   = has_final;
  assign status.out_free    = !out_valid || m_tready;

  // capture the input word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op    <= ple_pkg::mode_t'(s_tdata[1:0]);
      pos_a <= s_tdata[8:2];
      pos_b <= s_tdata[14:9];
      value <= s_tdata[46:15];
    end
  end

  // shift walk registers and held value
  assign neighbor = dir_up ? cursor + AW'(1) : cursor - AW'(1);

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      cursor     <= cursor_init;
      last_addr  <= last_init;
      fin_addr   <= fin_init;
      fetch_addr <= (op == ple_pkg::MODE_MERGE) ? lo[AW-1:0] : pos_a[AW-1:0];
      dir_up     <= dir_init;
      has_final  <= final_init;
      held       <= value;
    end else begin
      if (cmd.wr_shift) begin
        cursor <= neighbor;
      end
      if (cmd.hold_load) begin
        held <= rd_data;
      end else if (cmd.hold_add) begin
        held <= held + rd_data;
      end
    end
  end

  // memory port select
  always_comb begin
    case (cmd.rd_sel)
      ple_pkg::RD_FETCH:      rd_addr = fetch_addr;
      ple_pkg::RD_FETCH_NEXT: rd_addr = fetch_addr + AW'(1);
      ple_pkg::RD_NEIGHBOR:   rd_addr = neighbor;
      default:                rd_addr = fetch_addr;
    endcase
  end

  assign wr_en   = cmd.wr_shift || cmd.wr_final;
  assign wr_addr = cmd.wr_final ? fin_addr : cursor;
  assign wr_data = cmd.wr_final ? held : rd_data;

  // element memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // length and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
      out_valid     <= 1'b0;
    end else if (cmd.out_load) begin
      element_count <= count_next;
      out_valid     <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ok  <= ok;
      out_len <= count_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_len, out_ok};

endmodule

// ===== verif/tb.sv =====
// Testbench for positional_list_engine: a scoreboard class predicts every reply word.
// Directed and random list operations, bursty input side, stalling output side.
// Depends on hdl/ple_pkg.sv and hdl/positional_list_engine.sv.
module tb;

  localparam int CAPACITY     = ple_pkg::CAPACITY;
  localparam int LEN_W        = ple_pkg::LEN_W;
  localparam int VALUE_W      = ple_pkg::VALUE_W;
  localparam int POS_A_W      = ple_pkg::POS_A_W;
  localparam int POS_B_W      = ple_pkg::POS_B_W;
  localparam int IN_TDATA_W   = ple_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W  = ple_pkg::OUT_TDATA_W;

  localparam int RANDOM_WORDS = 1450;
  localparam int IDLE_LIMIT   = 4000;
  localparam int TAIL_CYCLES  = 2*CAPACITY + 16;
  localparam int REPORT_MAX   = 10;

  typedef enum int {MIX_GROW, MIX_EVEN, MIX_SHRINK} op_mix_t;
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_style_t;

  typedef struct {
    logic             ok;
    logic [LEN_W-1:0] length;
  } reply_t;

  // Shadow list plus the queue of reply words still owed by the block
  class list_scoreboard;
    logic [VALUE_W-1:0] elems [CAPACITY];
    int     count;
    reply_t replies [$];
    int     errors;
    int     words;
    int     applied;
    int     full_rejects;
    int     peak;

    function new();
      count = 0;
      errors = 0;
      words = 0;
      applied = 0;
      full_rejects = 0;
      peak = 0;
    endfunction

    // close the gap at position p
    function logic drop_at(int p);
      int i;
      for (i = p; i + 1 < count; i++) elems[i] = elems[i+1];
      count--;
      return 1'b1;
    endfunction

    // apply one accepted word to the shadow list and queue its reply
    function void note_word(ple_pkg::mode_t op, logic [POS_A_W-1:0] pos_a,
                            logic [POS_B_W-1:0] pos_b, logic [VALUE_W-1:0] val);
      int a;
      int b;
      int lo;
      int i;
      logic [VALUE_W-1:0] held;
      logic ok;
      reply_t r;
      a = pos_a;
      b = pos_b;
      ok = 1'b0;
      case (op)
        ple_pkg::MODE_INSERT: begin
          if (count >= CAPACITY) begin
            full_rejects++;
          end else if (a <= count) begin
            for (i = count; i > a; i--) elems[i] = elems[i-1];
            elems[a] = val;
            count++;
            ok = 1'b1;
          end
        end
        ple_pkg::MODE_DELETE: begin
          if (a < count) ok = drop_at(a);
        end
        ple_pkg::MODE_MOVE: begin
          // same position passes with no range check, but not on an empty list
          if (count != 0 && a == b) begin
            ok = 1'b1;
          end else if (count != 0 && a < count && b < count) begin
            held = elems[a];
            if (a < b) begin
              for (i = a; i < b; i++) elems[i] = elems[i+1];
            end else begin
              for (i = a; i > b; i--) elems[i] = elems[i-1];
            end
            elems[b] = held;
            ok = 1'b1;
          end
        end
        default: begin
          // adjacent pair only; the sum wraps to 32 bits
          lo = (a < b) ? a : b;
          if ((a + 1 == b || b + 1 == a) && lo + 1 < count) begin
            elems[lo] = elems[lo] + elems[lo+1];
            ok = drop_at(lo + 1);
          end
        end
      endcase
      words++;
      if (ok) applied++;
      if (count > peak) peak = count;
      r.ok = ok;
      r.length = LEN_W'(count);
      replies.push_back(r);
    endfunction

    // compare one reply word with the oldest expectation
    function void check_word(logic ok, logic [LEN_W-1:0] length);
      reply_t want;
      if (replies.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("tb: reply ok=%0d length=%0d arrived with no word pending", ok, length);
        return;
      end
      want = replies.pop_front();
      if (ok !== want.ok || length !== want.length) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("tb: reply mismatch: ok exp %0d got %0d, length exp %0d got %0d",
                   want.ok, ok, want.length, length);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  list_scoreboard sb = new();
  int idle_cycles = 0;

  positional_list_engine uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offer one word from a rising edge and hold it until accepted
  task automatic send_word(ple_pkg::mode_t op, logic [POS_A_W-1:0] pos_a,
                           logic [POS_B_W-1:0] pos_b, logic [VALUE_W-1:0] val);
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, val, pos_b, pos_a, op};
    do @(negedge clk); while (!s_tready);
    sb.note_word(op, pos_a, pos_b, val);
    @(posedge clk);
  endtask

  // Build one random word, mostly well formed for the current list length
  task automatic send_random(op_mix_t mix);
    int roll;
    int n;
    int lo;
    ple_pkg::mode_t op;
    logic [POS_A_W-1:0] pa;
    logic [POS_B_W-1:0] pb;
    logic [VALUE_W-1:0] val;
    n = sb.count;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: op = roll < 70 ? ple_pkg::MODE_INSERT : roll < 80 ? ple_pkg::MODE_DELETE :
                     roll < 90 ? ple_pkg::MODE_MOVE : ple_pkg::MODE_MERGE;
      MIX_SHRINK: op = roll < 15 ? ple_pkg::MODE_INSERT : roll < 70 ? ple_pkg::MODE_DELETE :
                       roll < 85 ? ple_pkg::MODE_MOVE : ple_pkg::MODE_MERGE;
      default: op = ple_pkg::mode_t'(roll % 4);
    endcase
    pa = POS_A_W'($urandom_range(0, CAPACITY));
    pb = POS_B_W'($urandom_range(0, CAPACITY - 1));
    if ($urandom_range(0, 99) < 85) begin
      case (op)
        ple_pkg::MODE_INSERT: pa = POS_A_W'($urandom_range(0, n));
        ple_pkg::MODE_DELETE: pa = POS_A_W'($urandom_range(0, n > 0 ? n - 1 : 0));
        ple_pkg::MODE_MOVE: begin
          pa = POS_A_W'($urandom_range(0, n > 0 ? n - 1 : 0));
          pb = POS_B_W'($urandom_range(0, n > 0 ? n - 1 : 0));
        end
        default: begin
          lo = $urandom_range(0, n > 1 ? n - 2 : 0);
          if ($urandom_range(0, 1)) begin
            pa = POS_A_W'(lo);
            pb = POS_B_W'(lo + 1);
          end else begin
            pa = POS_A_W'(lo + 1);
            pb = POS_B_W'(lo);
          end
        end
      endcase
    end else if ($urandom_range(0, 3) == 0) begin
      pb = pa[POS_B_W-1:0];
    end
    case ($urandom_range(0, 7))
      0: val = 32'h8000_0000;
      1: val = 32'h7FFF_FFFF;
      2: val = 32'hFFFF_FFFF;
      3: val = 32'h0000_0000;
      default: val = $urandom;
    endcase
    send_word(op, pa, pb, val);
  endtask

  // Output side: stall in a style that is picked anew at random after each span
  initial begin
    rx_style_t style;
    int span;
    forever begin
      style = rx_style_t'($urandom_range(0, 3));
      span = $urandom_range(40, 300);
      repeat (span) begin
        @(posedge clk);
        case (style)
          RX_OPEN:   m_tready <= 1'b1;
          RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
          default:   m_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Check each reply word just before the edge that accepts it
  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_word(m_tdata[0], m_tdata[LEN_W:1]);
  end

  // Watchdog: end the run when no word moves on either side for too long
  always @(negedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    int sent;
    int phase;
    int phase_len;
    int burst;
    int gap;
    op_mix_t mix;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list: every operation refused, insert beyond the end too
    send_word(ple_pkg::MODE_INSERT, 7'd1, 6'd0, 32'h1111_1111);
    send_word(ple_pkg::MODE_DELETE, 7'd0, 6'd0, 32'h0);
    send_word(ple_pkg::MODE_MOVE,   7'd0, 6'd0, 32'h0);
    send_word(ple_pkg::MODE_MERGE,  7'd0, 6'd1, 32'h0);
    // merges, the second of which wraps, with the pair given in both orders
    send_word(ple_pkg::MODE_INSERT, 7'd0, 6'd0, 32'h7FFF_FFFF);
    send_word(ple_pkg::MODE_INSERT, 7'd1, 6'd0, 32'h0000_0001);
    send_word(ple_pkg::MODE_MERGE,  7'd1, 6'd0, 32'h0);
    send_word(ple_pkg::MODE_INSERT, 7'd1, 6'd63, 32'h8000_0000);
    send_word(ple_pkg::MODE_MERGE,  7'd0, 6'd1, 32'h0);
    send_word(ple_pkg::MODE_INSERT, 7'd0, 6'd0, 32'hFFFF_FFFF);
    send_word(ple_pkg::MODE_INSERT, 7'd2, 6'd0, 32'h1234_5678);
    // out-of-range inserts and deletes
    send_word(ple_pkg::MODE_INSERT, 7'd4, 6'd0, 32'h5555_5555);
    send_word(ple_pkg::MODE_INSERT, 7'd64, 6'd0, 32'h8000_0000);
    send_word(ple_pkg::MODE_DELETE, 7'd3, 6'd0, 32'h0);
    send_word(ple_pkg::MODE_DELETE, 7'd64, 6'd63, 32'hFFFF_FFFF);
    // moves: same position unchecked, down, up, out of range
    send_word(ple_pkg::MODE_MOVE,   7'd63, 6'd63, 32'h0);
    send_word(ple_pkg::MODE_MOVE,   7'd2, 6'd0, 32'h0);
    send_word(ple_pkg::MODE_MOVE,   7'd0, 6'd2, 32'h0);
    send_word(ple_pkg::MODE_MOVE,   7'd0, 6'd5, 32'h0);
    send_word(ple_pkg::MODE_MOVE,   7'd64, 6'd0, 32'h0);
    // merges refused: not adjacent, equal, past the end
    send_word(ple_pkg::MODE_MERGE,  7'd0, 6'd2, 32'h0);
    send_word(ple_pkg::MODE_MERGE,  7'd1, 6'd1, 32'h0);
    send_word(ple_pkg::MODE_MERGE,  7'd2, 6'd3, 32'h0);
    send_word(ple_pkg::MODE_DELETE, 7'd1, 6'd0, 32'h0);

    // random phases: mostly grow, mix, mostly shrink, mix
    sent = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      case (phase % 4)
        0: mix = MIX_GROW;
        2: mix = MIX_SHRINK;
        default: mix = MIX_EVEN;
      endcase
      // hold off until every owed reply has come back
      if (sb.replies.size() != 0) begin
        s_tvalid <= 1'b0;
        while (sb.replies.size() != 0) @(posedge clk);
      end
      phase_len = $urandom_range(60, 200);
      if (phase_len > RANDOM_WORDS - sent) phase_len = RANDOM_WORDS - sent;
      burst = 0;
      repeat (phase_len) begin
        if (burst == 0) begin
          burst = $urandom_range(1, 40);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        send_random(mix);
        burst--;
        sent++;
      end
      phase++;
    end

    // drain and let the block settle
    s_tvalid <= 1'b0;
    while (sb.replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d words over %0d random phases, %0d applied, %0d refused",
             sb.words, phase, sb.applied, sb.words - sb.applied);
    $display("tb: longest list %0d, %0d inserts refused on a full list, %0d mismatches",
             sb.peak, sb.full_rejects, sb.errors);
    if (sb.errors == 0 && sb.replies.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ple_pkg.sv
hdl/ple_ctrl.sv
hdl/ple_datapath.sv
hdl/positional_list_engine.sv
verif/tb.sv
